// ===== rtl/prqs_pkg.sv =====
`default_nettype none

package prqs_pkg;

    // Field widths of the command and result transactions.
    localparam int TASK_W  = 8;
    localparam int PRIO_W  = 8;
    localparam int EVT_W   = 32;
    localparam int CMD_W   = 2;
    localparam int ACT_W   = 3;
    localparam int ENTRY_W = 1 + PRIO_W + TASK_W;

    // Defaults for the top-level parameters.
    localparam int MAX_TASKS_DEF  = 16;
    localparam int EVENT_BITS_DEF = 32;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_TERM = 2'd2
    } cmd_t;

    // Result action codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_DROP     = 3'd1,
        ACT_IDLE     = 3'd2,
        ACT_DISPATCH = 3'd3,
        ACT_WAIT     = 3'd4,
        ACT_PREEMPT  = 3'd5
    } action_t;

    // One ready queue entry, laid out as full-preempt flag, priority, task id.
    typedef struct packed {
        logic              pf;
        logic [PRIO_W-1:0] prio;
        logic [TASK_W-1:0] id;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // capture the accepted transaction
        logic    rd_head;     // read the queue head
        logic    walk_start;  // start the insert walk at the top entry
        logic    walk_step;   // move the insert walk one entry down
        logic    pop;         // head becomes the current task
        logic    requeue;     // with pop: old current task is the entry to insert
        logic    displace;    // report the current task as moved out
        logic    clear_cur;   // drop the current task
        logic    shift_wr;    // move the entry under the walk up by one
        logic    place;       // write the entry to insert and grow the queue
        logic    place_low;   // with place: write it at the bottom slot
        logic    set_action;  // load the action code below
        action_t action;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic count_zero;
        logic count_full;
        logic cur_valid;
        logic waiting;
        logic cur_pf;
        logic head_higher;  // head priority above the current task's
        logic walk_gt;      // entry under the walk outranks the new entry
        logic idx_zero;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/prqs_ram.sv =====
`default_nettype none

module prqs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/prqs_datapath.sv =====
`default_nettype none

module prqs_datapath #(
    parameter int MAX_TASKS  = 16,
    parameter int EVENT_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  prqs_pkg::ctrl_cmd_t            ctl,
    output prqs_pkg::dp_status_t           sts,
    input  logic [prqs_pkg::CMD_W-1:0]     cmd,
    input  logic [prqs_pkg::TASK_W-1:0]    task_id,
    input  logic [prqs_pkg::PRIO_W-1:0]    priority_req,
    input  logic                           preempt_full,
    input  logic [prqs_pkg::EVT_W-1:0]     wait_mask,
    input  logic [prqs_pkg::EVT_W-1:0]     wait_value,
    output logic [prqs_pkg::ACT_W-1:0]     action,
    output logic                           dispatch_valid,
    output logic [prqs_pkg::TASK_W-1:0]    dispatch_task,
    output logic                           displaced_valid,
    output logic [prqs_pkg::TASK_W-1:0]    displaced_task,
    output logic                           current_valid
);

    import prqs_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = $clog2(MAX_TASKS);
    localparam logic [EVT_W-1:0] EvtMask = (EVENT_BITS >= EVT_W) ? {EVT_W{1'b1}} :
        EVT_W'((65'(1) << EVENT_BITS) - 65'(1));

    logic [CW-1:0]     count_reg, count_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [TASK_W-1:0] cur_task_reg, cur_task_next;
    logic [PRIO_W-1:0] cur_prio_reg, cur_prio_next;
    logic              cur_pf_reg, cur_pf_next;
    cmd_t              cmd_reg, cmd_next;
    logic              waiting_reg, waiting_next;
    entry_t            ins_reg, ins_next;
    logic [IW-1:0]     idx_reg, idx_next;
    action_t           action_reg, action_next;
    logic              disp_v_reg, disp_v_next;
    logic [TASK_W-1:0] disp_t_reg, disp_t_next;
    logic              dsp_v_reg, dsp_v_next;
    logic [TASK_W-1:0] dsp_t_reg, dsp_t_next;

    logic [EVT_W-1:0]   masked_mask, masked_value;
    logic               waiting_now;
    logic [IW-1:0]      top_idx;
    logic [IW-1:0]      raddr, waddr;
    logic               re, we;
    logic [ENTRY_W-1:0] wdata, rdata_raw;
    entry_t             rdata;

    // Waiting test on the event bits of the accepted transaction.
    assign masked_mask  = wait_mask & EvtMask;
    assign masked_value = wait_value & EvtMask;
    assign waiting_now  = (masked_mask != '0) && (masked_mask != masked_value);

    // The queue is kept in ascending order with the head at the top slot.
    assign top_idx = IW'(count_reg - CW'(1));
    assign re      = ctl.rd_head | ctl.walk_start | ctl.walk_step;
    assign raddr   = ctl.walk_step ? (idx_reg - IW'(1)) : top_idx;
    assign we      = ctl.shift_wr | ctl.place;
    assign waddr   = (ctl.place && ctl.place_low) ? '0 : (idx_reg + IW'(1));
    assign wdata   = ctl.place ? ENTRY_W'(ins_reg) : rdata_raw;
    assign rdata   = entry_t'(rdata_raw);

    prqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_queue (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    // Next-state logic for the scheduler state and the result.
    always_comb
    begin
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_task_next  = cur_task_reg;
        cur_prio_next  = cur_prio_reg;
        cur_pf_next    = cur_pf_reg;
        cmd_next       = cmd_reg;
        waiting_next   = waiting_reg;
        ins_next       = ins_reg;
        idx_next       = idx_reg;
        action_next    = action_reg;
        disp_v_next    = disp_v_reg;
        disp_t_next    = disp_t_reg;
        dsp_v_next     = dsp_v_reg;
        dsp_t_next     = dsp_t_reg;

        if (ctl.load)
        begin
            cmd_next     = cmd_t'(cmd);
            waiting_next = waiting_now;
            ins_next     = '{pf: preempt_full, prio: priority_req, id: task_id};
            action_next  = ACT_NONE;
            disp_v_next  = 1'b0;
            disp_t_next  = '0;
            dsp_v_next   = 1'b0;
            dsp_t_next   = '0;
        end
        if (ctl.set_action)
        begin
            action_next = ctl.action;
        end
        if (ctl.displace)
        begin
            dsp_v_next = 1'b1;
            dsp_t_next = cur_task_reg;
        end
        if (ctl.clear_cur)
        begin
            cur_valid_next = 1'b0;
        end
        // The head leaves the queue and becomes the current task.
        if (ctl.pop)
        begin
            cur_valid_next = 1'b1;
            cur_task_next  = rdata.id;
            cur_prio_next  = rdata.prio;
            cur_pf_next    = rdata.pf;
            count_next     = count_reg - CW'(1);
            disp_v_next    = 1'b1;
            disp_t_next    = rdata.id;
            if (ctl.requeue)
            begin
                ins_next = '{pf: cur_pf_reg, prio: cur_prio_reg, id: cur_task_reg};
            end
        end
        if (ctl.walk_start)
        begin
            idx_next = top_idx;
        end
        if (ctl.walk_step)
        begin
            idx_next = idx_reg - IW'(1);
        end
        if (ctl.place)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_task_reg  <= '0;
            cur_prio_reg  <= '0;
            cur_pf_reg    <= 1'b0;
            cmd_reg       <= CMD_ADD;
            waiting_reg   <= 1'b0;
            action_reg    <= ACT_NONE;
            disp_v_reg    <= 1'b0;
            dsp_v_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            cur_task_reg  <= cur_task_next;
            cur_prio_reg  <= cur_prio_next;
            cur_pf_reg    <= cur_pf_next;
            cmd_reg       <= cmd_next;
            waiting_reg   <= waiting_next;
            action_reg    <= action_next;
            disp_v_reg    <= disp_v_next;
            dsp_v_reg     <= dsp_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ins_reg    <= ins_next;
        idx_reg    <= idx_next;
        disp_t_reg <= disp_t_next;
        dsp_t_reg  <= dsp_t_next;
    end

    // Status towards the controller.
    assign sts.cmd         = cmd_reg;
    assign sts.count_zero  = (count_reg == '0);
    assign sts.count_full  = (count_reg == CW'(MAX_TASKS));
    assign sts.cur_valid   = cur_valid_reg;
    assign sts.waiting     = waiting_reg;
    assign sts.cur_pf      = cur_pf_reg;
    assign sts.head_higher = (cur_prio_reg < rdata.prio);
    assign sts.walk_gt     = (rdata.prio > ins_reg.prio);
    assign sts.idx_zero    = (idx_reg == '0);

    // Result ports.
    assign action          = action_reg;
    assign dispatch_valid  = disp_v_reg;
    assign dispatch_task   = disp_t_reg;
    assign displaced_valid = dsp_v_reg;
    assign displaced_task  = dsp_t_reg;
    assign current_valid   = cur_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/prqs_ctrl.sv =====
`default_nettype none

module prqs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  prqs_pkg::dp_status_t sts,
    output prqs_pkg::ctrl_cmd_t  ctl
);

    import prqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HEAD_POP,
        S_HEAD_CHK,
        S_INS_START,
        S_INS_CMP,
        S_INS_BOTTOM
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // Sequencing of one transaction.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                unique case (sts.cmd)
                    CMD_ADD:
                    begin
                        if (sts.count_full)
                        begin
                            ctl.set_action = 1'b1;
                            ctl.action     = ACT_DROP;
                            state_next     = S_IDLE;
                            done_next      = 1'b1;
                        end
                        else
                        begin
                            state_next = S_INS_START;
                        end
                    end

                    CMD_TICK:
                    begin
                        if (!sts.cur_valid)
                        begin
                            ctl.set_action = 1'b1;
                            if (sts.count_zero)
                            begin
                                ctl.action = ACT_IDLE;
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ctl.action  = ACT_DISPATCH;
                                ctl.rd_head = 1'b1;
                                state_next  = S_HEAD_POP;
                            end
                        end
                        else if (sts.waiting)
                        begin
                            // The current task goes to wait; the head follows it.
                            ctl.set_action = 1'b1;
                            ctl.action     = ACT_WAIT;
                            ctl.displace   = 1'b1;
                            ctl.clear_cur  = 1'b1;
                            if (sts.count_zero)
                            begin
                                state_next = S_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ctl.rd_head = 1'b1;
                                state_next  = S_HEAD_POP;
                            end
                        end
                        else if (sts.cur_pf && !sts.count_zero)
                        begin
                            ctl.rd_head = 1'b1;
                            state_next  = S_HEAD_CHK;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            done_next  = 1'b1;
                        end
                    end

                    CMD_TERM:
                    begin
                        ctl.clear_cur = 1'b1;
                        state_next    = S_IDLE;
                        done_next     = 1'b1;
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                endcase
            end

            S_HEAD_POP:
            begin
                ctl.pop    = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end

            // Preemption check: a head that outranks a fully preemptive current task replaces it.
            S_HEAD_CHK:
            begin
                if (sts.head_higher)
                begin
                    ctl.pop        = 1'b1;
                    ctl.requeue    = 1'b1;
                    ctl.displace   = 1'b1;
                    ctl.set_action = 1'b1;
                    ctl.action     = ACT_PREEMPT;
                    state_next     = S_INS_START;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            S_INS_START:
            begin
                if (sts.count_zero)
                begin
                    ctl.place     = 1'b1;
                    ctl.place_low = 1'b1;
                    state_next    = S_IDLE;
                    done_next     = 1'b1;
                end
                else
                begin
                    ctl.walk_start = 1'b1;
                    state_next     = S_INS_CMP;
                end
            end

            // Entries that outrank the new one move up one slot at a time.
            S_INS_CMP:
            begin
                if (sts.walk_gt)
                begin
                    ctl.shift_wr = 1'b1;
                    if (sts.idx_zero)
                    begin
                        state_next = S_INS_BOTTOM;
                    end
                    else
                    begin
                        ctl.walk_step = 1'b1;
                    end
                end
                else
                begin
                    ctl.place  = 1'b1;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            S_INS_BOTTOM:
            begin
                ctl.place     = 1'b1;
                ctl.place_low = 1'b1;
                state_next    = S_IDLE;
                done_next     = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/priority_ready_queue_scheduler.sv =====
`default_nettype none

// Ready queue for a priority task scheduler, with one current task.
// A command transaction is taken at a rising edge with start high and busy
// low: cmd selects add task, schedule tick or terminate current task.
// Each command yields exactly one result transaction, shown for one cycle
// with done high: action, dispatched task, displaced task and whether a
// current task remains. The receiver cannot stall; done is a plain strobe.
// The sorted insert of an add or a preempting tick moves one queue entry per
// cycle through the single write port of the queue memory. busy drops in the
// cycle that done is high, so the next command may be taken then; one command
// is in work at a time.
// Reset empties the queue and clears the current task; queue memory
// contents need no clearing, only slots below the fill count are read.

module priority_ready_queue_scheduler #(
    parameter int MAX_TASKS  = prqs_pkg::MAX_TASKS_DEF,
    parameter int EVENT_BITS = prqs_pkg::EVENT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [prqs_pkg::CMD_W-1:0]  cmd,
    input  logic [prqs_pkg::TASK_W-1:0] task_id,
    input  logic [prqs_pkg::PRIO_W-1:0] priority_req,
    input  logic                        preempt_full,
    input  logic [prqs_pkg::EVT_W-1:0]  wait_mask,
    input  logic [prqs_pkg::EVT_W-1:0]  wait_value,
    output logic                        done,
    output logic [prqs_pkg::ACT_W-1:0]  action,
    output logic                        dispatch_valid,
    output logic [prqs_pkg::TASK_W-1:0] dispatch_task,
    output logic                        displaced_valid,
    output logic [prqs_pkg::TASK_W-1:0] displaced_task,
    output logic                        current_valid
);

    import prqs_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    // Sequencer.
    prqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .ctl   (ctl)
    );

    // Queue memory, current task and result registers.
    prqs_datapath #(
        .MAX_TASKS  (MAX_TASKS),
        .EVENT_BITS (EVENT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cmd             (cmd),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .preempt_full    (preempt_full),
        .wait_mask       (wait_mask),
        .wait_value      (wait_value),
        .action          (action),
        .dispatch_valid  (dispatch_valid),
        .dispatch_task   (dispatch_task),
        .displaced_valid (displaced_valid),
        .displaced_task  (displaced_task),
        .current_valid   (current_valid)
    );

endmodule

`default_nettype wire
